/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define USBHF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("usbhf assertion failed");

// Checked at every edge, reset included.
`define USBHF_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("usbhf assertion failed");

`endif

/* rtl/usbhf_pkg.sv */
package usbhf_pkg;

   localparam int CMD_W   = 2;
   localparam int LEN_W   = 16;
   localparam int OS_W    = 2;
   localparam int COUNT_W = 8;
   localparam int MS_W    = 16;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_SETUP = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [OS_W-1:0] {
      GUESS_UNSURE  = 2'd0,
      GUESS_WINDOWS = 2'd1,
      GUESS_MACOS   = 2'd2,
      GUESS_LINUX   = 2'd3
   } os_type;

   localparam logic [LEN_W-1:0]   LEN_TWO            = 16'h0002;
   localparam logic [LEN_W-1:0]   LEN_FOUR           = 16'h0004;
   localparam logic [LEN_W-1:0]   LEN_FULL           = 16'h00FF;
   localparam logic [MS_W-1:0]    DEBOUNCE_RESET     = 16'd300;
   localparam logic [COUNT_W-1:0] MACOS_MIN_REQUESTS = 8'd5;
   localparam logic [COUNT_W-1:0] CLASSIFY_MIN       = 8'd3;
   localparam logic [ADDR_W-1:0]  ADDR_DEBOUNCE      = 2'd0;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [LEN_W-1:0] wlength;
   } req_word_type;

   typedef struct packed {
      logic [OS_W-1:0]    reported_os;
      logic [OS_W-1:0]    latched_os;
      logic [COUNT_W-1:0] request_count;
   } rsp_word_type;

endpackage

/* rtl/usbhf_req_if.sv */
interface usbhf_req_if import usbhf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [LEN_W-1:0] wlength;

   modport source (output valid, cmd, wlength, input ready);
   modport sink (input valid, cmd, wlength, output ready);
endinterface

/* rtl/usbhf_rsp_if.sv */
interface usbhf_rsp_if import usbhf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OS_W-1:0]    reported_os;
   logic [OS_W-1:0]    latched_os;
   logic [COUNT_W-1:0] request_count;

   modport source (output valid, reported_os, latched_os, request_count, input ready);
   modport sink (input valid, reported_os, latched_os, request_count, output ready);
endinterface

/* rtl/usbhf_csr.sv */
module usbhf_csr import usbhf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [MS_W-1:0]   debounce_ms
);
   logic [MS_W-1:0] debounce_ff;
   logic [MS_W-1:0] debounce_in;
   logic            wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == ADDR_DEBOUNCE);

   always_comb begin
      debounce_in = debounce_ff;
      if (wr_hit) begin
         debounce_in = pwdata[MS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else begin
         debounce_ff <= debounce_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == ADDR_DEBOUNCE) begin
         prdata = {{(DATA_W-MS_W){1'b0}}, debounce_ff};
      end
   end

   assign debounce_ms = debounce_ff;
endmodule

/* rtl/usbhf_core.sv */
module usbhf_core import usbhf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_word_type    word,
   input  logic [MS_W-1:0] debounce_ms,
   output rsp_word_type    result
);
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] two_ff, two_in;
   logic [COUNT_W-1:0] four_ff, four_in;
   logic [COUNT_W-1:0] full_ff, full_in;
   logic               last_full_ff, last_full_in;
   os_type             guess_ff, guess_in;
   logic [MS_W-1:0]    elapsed_ff, elapsed_in;
   logic               active_ff, active_in;

   logic               is_two, is_four, is_full;
   logic [COUNT_W-1:0] tot_s, two_s, four_s, full_s;
   os_type             rule;
   os_type             reported;

   assign is_two  = (word.wlength == LEN_TWO);
   assign is_four = (word.wlength == LEN_FOUR);
   assign is_full = (word.wlength == LEN_FULL);
   assign tot_s   = total_ff + COUNT_W'(1);
   assign two_s   = two_ff + COUNT_W'(is_two);
   assign four_s  = four_ff + COUNT_W'(is_four);
   assign full_s  = full_ff + COUNT_W'(is_full);

   // ordered classification rules on the counts after this request
   always_comb begin
      rule = GUESS_UNSURE;
      if (tot_s >= CLASSIFY_MIN) begin
         priority if (full_s >= COUNT_W'(2) && four_s != '0) begin
            rule = GUESS_WINDOWS;
         end else if (tot_s == full_s) begin
            rule = GUESS_LINUX;
         end else if (tot_s >= MACOS_MIN_REQUESTS && is_full && full_s != '0
                      && two_s >= COUNT_W'(2)) begin
            rule = GUESS_MACOS;
         end else if (full_s != '0 && two_s == '0 && four_s == '0) begin
            rule = GUESS_LINUX;
         end else begin
            rule = GUESS_UNSURE;
         end
      end
   end

   always_comb begin
      total_in     = total_ff;
      two_in       = two_ff;
      four_in      = four_ff;
      full_in      = full_ff;
      last_full_in = last_full_ff;
      guess_in     = guess_ff;
      elapsed_in   = elapsed_ff;
      active_in    = active_ff;
      reported     = GUESS_UNSURE;
      unique case (cmd_type'(word.cmd))
         CMD_SETUP: begin
            total_in     = tot_s;
            two_in       = two_s;
            four_in      = four_s;
            full_in      = full_s;
            last_full_in = is_full;
            if (rule != GUESS_UNSURE) begin
               guess_in = rule;
            end
            elapsed_in = '0;
            active_in  = 1'b1;
         end
         CMD_TICK: begin
            if (elapsed_ff != '1) begin
               elapsed_in = elapsed_ff + MS_W'(1);
            end
         end
         CMD_QUERY: begin
            priority if (active_ff && elapsed_ff < debounce_ms) begin
               reported = GUESS_UNSURE;
            end else if (!active_ff && guess_ff == GUESS_UNSURE) begin
               reported = GUESS_UNSURE;
            end else begin
               active_in = 1'b0;
               reported  = guess_ff;
            end
         end
         CMD_CLEAR: begin
            total_in     = '0;
            two_in       = '0;
            four_in      = '0;
            full_in      = '0;
            last_full_in = 1'b0;
            guess_in     = GUESS_UNSURE;
            elapsed_in   = '0;
            active_in    = 1'b0;
         end
         default: begin
            reported = GUESS_UNSURE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         two_ff       <= '0;
         four_ff      <= '0;
         full_ff      <= '0;
         last_full_ff <= 1'b0;
         guess_ff     <= GUESS_UNSURE;
         elapsed_ff   <= '0;
         active_ff    <= 1'b0;
      end else if (advance) begin
         total_ff     <= total_in;
         two_ff       <= two_in;
         four_ff      <= four_in;
         full_ff      <= full_in;
         last_full_ff <= last_full_in;
         guess_ff     <= guess_in;
         elapsed_ff   <= elapsed_in;
         active_ff    <= active_in;
      end
   end

   assign result.reported_os   = reported;
   assign result.latched_os    = guess_in;
   assign result.request_count = total_in;
endmodule

/* rtl/usbhf_out_reg.sv */
module usbhf_out_reg import usbhf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type word,
   output logic         full,
   usbhf_rsp_if.source  rsp_ch
);
   logic         valid_ff, valid_in;
   rsp_word_type word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign full                 = valid_ff;
   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.reported_os   = word_ff.reported_os;
   assign rsp_ch.latched_os    = word_ff.latched_os;
   assign rsp_ch.request_count = word_ff.request_count;
endmodule

/* rtl/usb_host_os_fingerprint_unit.sv */
// channel   | dir | handshake     | payload
// req_ch    | in  | valid / ready | cmd[1:0], wlength[15:0]
// rsp_ch    | out | valid / ready | reported_os[1:0], latched_os[1:0], request_count[7:0]
// csr (APB) | in  | psel/penable  | debounce_ms at byte address 0
//
// One word per cycle sustained while rsp_ch is not stalled; a word passes through the input
// register, then the classifier and state update feeding the result register.
// The counters and latched guess update when a word moves into the result register.
// A stalled rsp_ch holds the result register; one more word waits in the
// input register and req_ch.ready drops only when both are full.
// Reset clears the counters, guess and valid flags and sets debounce_ms to 300.
module usb_host_os_fingerprint_unit import usbhf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   usbhf_req_if.sink         req_ch,
   usbhf_rsp_if.source       rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);
   logic            in_valid_ff, in_valid_in;
   req_word_type    in_word_ff;
   logic            advance;
   logic            out_full;
   logic [MS_W-1:0] debounce_ms;
   rsp_word_type    result;

   // the input word moves on whenever the result register is free or draining
   assign advance      = in_valid_ff && (!out_full || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_word_ff.cmd     <= req_ch.cmd;
         in_word_ff.wlength <= req_ch.wlength;
      end
   end

   usbhf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .debounce_ms (debounce_ms)
   );

   usbhf_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .word        (in_word_ff),
      .debounce_ms (debounce_ms),
      .result      (result)
   );

   usbhf_out_reg u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (advance),
      .word   (result),
      .full   (out_full),
      .rsp_ch (rsp_ch)
   );
endmodule

/* rtl/usbhf_checker.sv */
`include "assert_macros.svh"

module usbhf_checker import usbhf_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [OS_W-1:0] reported_os,
   input logic [OS_W-1:0] latched_os
);
   // a pending result word stays up until taken
   `USBHF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   // nothing is shown right after reset
   `USBHF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)
   // a definite answer is always the latched guess
   `USBHF_ASSERT(a_answer_latched,
      rsp_valid && reported_os != GUESS_UNSURE |-> reported_os == latched_os)
   // an accepted word reaches the output through the input register and the result register
   `USBHF_ASSERT(a_latency, req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
endmodule

bind usb_host_os_fingerprint_unit usbhf_checker u_usbhf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .reported_os (rsp_ch.reported_os),
   .latched_os  (rsp_ch.latched_os)
);

/* sim/tb_usb_host_os_fingerprint_unit.sv */
module tb_usb_host_os_fingerprint_unit;
   import usbhf_pkg::*;

   localparam int RUN_LIMIT  = 100_000;
   localparam int LONG_HOLD  = 150;
   localparam int WIDE_TICKS = 20;
   localparam int DRAIN_WAIT = 6;

   // Tracks the OS guesser state and the result words it must produce.
   class os_guess_predictor;
      logic [MS_W-1:0]    debounce_ms;
      logic [COUNT_W-1:0] total_requests;
      logic [COUNT_W-1:0] n_two;
      logic [COUNT_W-1:0] n_four;
      logic [COUNT_W-1:0] n_full;
      logic               last_full;
      os_type             latched;
      logic [MS_W-1:0]    elapsed_ms;
      logic               window_open;
      rsp_word_type       expected_words[$];
      int                 mismatches;

      function new();
         debounce_ms = DEBOUNCE_RESET;
         mismatches  = 0;
         clear_counts();
      endfunction

      function void clear_counts();
         total_requests = '0;
         n_two          = '0;
         n_four         = '0;
         n_full         = '0;
         last_full      = 1'b0;
         latched        = GUESS_UNSURE;
         elapsed_ms     = '0;
         window_open    = 1'b0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_word(cmd_type c, logic [LEN_W-1:0] len);
         rsp_word_type w;
         os_type       guess;
         os_type       answer;
         answer = GUESS_UNSURE;
         guess  = GUESS_UNSURE;
         case (c)
            CMD_SETUP: begin
               total_requests = total_requests + 1'b1;
               last_full      = (len == LEN_FULL);
               if (len == LEN_TWO) n_two = n_two + 1'b1;
               else if (len == LEN_FOUR) n_four = n_four + 1'b1;
               else if (len == LEN_FULL) n_full = n_full + 1'b1;
               // rules are ordered; first match wins
               if (total_requests >= CLASSIFY_MIN) begin
                  if (n_full >= 8'd2 && n_four >= 8'd1)
                     guess = GUESS_WINDOWS;
                  else if (total_requests == n_full)
                     guess = GUESS_LINUX;
                  else if (total_requests >= MACOS_MIN_REQUESTS && last_full &&
                           n_full >= 8'd1 && n_two >= 8'd2)
                     guess = GUESS_MACOS;
                  else if (n_full != 0 && n_two == 0 && n_four == 0)
                     guess = GUESS_LINUX;
               end
               if (guess != GUESS_UNSURE) latched = guess;
               elapsed_ms  = '0;
               window_open = 1'b1;
            end
            CMD_TICK: begin
               if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
            end
            CMD_QUERY: begin
               if (window_open && elapsed_ms < debounce_ms)
                  answer = GUESS_UNSURE;
               else if (!window_open && latched == GUESS_UNSURE)
                  answer = GUESS_UNSURE;
               else begin
                  window_open = 1'b0;
                  answer      = latched;
               end
            end
            default: clear_counts();
         endcase
         w.reported_os   = answer;
         w.latched_os    = latched;
         w.request_count = total_requests;
         expected_words.push_back(w);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: reported_os %0d latched_os %0d request_count %0d",
                   got.reported_os, got.latched_os, got.request_count);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         if (got.reported_os !== want.reported_os) begin
            $error("reported_os: expected %0d, got %0d", want.reported_os, got.reported_os);
            mismatches++;
         end
         if (got.latched_os !== want.latched_os) begin
            $error("latched_os: expected %0d, got %0d", want.latched_os, got.latched_os);
            mismatches++;
         end
         if (got.request_count !== want.request_count) begin
            $error("request_count: expected %0d, got %0d",
                   want.request_count, got.request_count);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int idle_max;
   int hold_cycles;
   int cycle_count;
   int csr_errors;

   os_guess_predictor board = new();

   usbhf_req_if req_if ();
   usbhf_rsp_if rsp_if ();

   usb_host_os_fingerprint_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random stall before each word, plus one long hold on request.
   initial begin
      int           stall;
      rsp_word_type got;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, idle_max);
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.reported_os   = rsp_if.reported_os;
         got.latched_os    = rsp_if.latched_os;
         got.request_count = rsp_if.request_count;
         board.check_word(got);
         @(negedge clock);
      end
   end

   // All driving tasks start and end at a falling edge.
   task automatic send_word(input cmd_type c, input logic [LEN_W-1:0] len);
      int gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= c;
      req_if.wlength <= len;
      do @(posedge clock); while (!req_if.ready);
      board.note_word(c, len);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_debounce(input logic [MS_W-1:0] value);
      logic [DATA_W-1:0] readback;
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_DEBOUNCE;
      pwdata  <= {{(DATA_W-MS_W){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      board.debounce_ms = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[MS_W-1:0] !== value) begin
         $error("debounce_ms readback: expected %0d, got %0d", value, readback[MS_W-1:0]);
         csr_errors++;
      end
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0, 1:    return LEN_TWO;
         2, 3:    return LEN_FOUR;
         4, 5, 6: return LEN_FULL;
         7:       return LEN_W'($urandom_range(0, 65535));
         8:       return LEN_W'($urandom_range(0, 7));
         default: return {8'($urandom_range(0, 255)), 8'hFF};
      endcase
   endfunction

   task automatic send_random(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) send_word(CMD_SETUP, pick_length());
         else if (r < 75) send_word(CMD_TICK, LEN_W'($urandom_range(0, 65535)));
         else if (r < 95) send_word(CMD_QUERY, LEN_W'($urandom_range(0, 65535)));
         else send_word(CMD_CLEAR, LEN_W'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      logic [MS_W-1:0] phase_debounce [5];
      int              phase_idle [5];
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_if.valid   = 1'b0;
      req_if.cmd     = CMD_TICK;
      req_if.wlength = '0;
      idle_max       = 10;
      hold_cycles    = 0;
      cycle_count    = 0;
      csr_errors     = 0;
      phase_debounce = '{16'd3, 16'd0, 16'hFFFF, 16'd1, DEBOUNCE_RESET};
      phase_idle     = '{10, 0, 10, 10, 0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset debounce window
      send_word(CMD_QUERY, 16'h0000);
      repeat (3) send_word(CMD_SETUP, LEN_FULL);
      send_word(CMD_QUERY, 16'hFFFF);
      send_word(CMD_SETUP, LEN_FOUR);
      send_word(CMD_TICK, 16'hA5A5);
      send_word(CMD_CLEAR, 16'h5A5A);
      send_word(CMD_SETUP, LEN_TWO);
      send_word(CMD_SETUP, LEN_FULL);
      send_word(CMD_SETUP, LEN_TWO);
      send_word(CMD_SETUP, 16'hFFFF);
      send_word(CMD_SETUP, LEN_FULL);
      send_word(CMD_SETUP, 16'h0000);
      send_word(CMD_CLEAR, 16'h0000);
      send_word(CMD_SETUP, LEN_FULL);
      send_word(CMD_SETUP, LEN_FULL);
      send_word(CMD_SETUP, 16'h0100);
      send_word(CMD_TICK, 16'h0000);

      // zero window: query returns the guess at once, even when unsure
      write_debounce(16'd0);
      send_word(CMD_QUERY, 16'h0000);
      send_word(CMD_QUERY, 16'h0000);
      send_word(CMD_CLEAR, 16'h0000);
      send_word(CMD_SETUP, 16'h0007);
      send_word(CMD_QUERY, 16'h0000);
      send_word(CMD_QUERY, 16'h0000);

      // widest window; queries stay unsure while ticks run
      write_debounce(16'hFFFF);
      idle_max = 0;
      repeat (3) send_word(CMD_SETUP, LEN_FULL);
      send_word(CMD_QUERY, 16'h0000);
      repeat (WIDE_TICKS) send_word(CMD_TICK, 16'h0000);
      send_word(CMD_QUERY, 16'h0000);

      // long request runs so the 8-bit counters wrap
      write_debounce(16'd1);
      idle_max = 10;
      send_word(CMD_CLEAR, 16'h0000);
      for (int i = 0; i < 280; i++) begin
         if (i % 35 == 34) send_word(CMD_QUERY, 16'h0000);
         else if (i % 35 == 33) send_word(CMD_TICK, 16'h0000);
         else send_word(CMD_SETUP, pick_length());
      end

      for (int p = 0; p < 5; p++) begin
         write_debounce(phase_debounce[p]);
         idle_max = phase_idle[p];
         send_random(20);
         if (p == 1) begin
            // receiver holds off while words keep coming, then sender waits it out
            hold_cycles = LONG_HOLD;
            repeat (24) send_word(CMD_SETUP, pick_length());
            drain();
         end
         send_random(20);
      end

      drain();
      repeat (10) @(negedge clock);
      if (board.pending() != 0)
         $error("%0d expected result words never arrived", board.pending());
      if (board.mismatches == 0 && csr_errors == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
